[rtl/core/infix_to_postfix_converter_unit_assert.svh]
// assertion macros used by the converter checker file
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define IPC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ipc_pkg.sv]
// shared types, character constants and decode functions of the infix to postfix converter
`timescale 1ns / 1ps

package ipc_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_EQ   = 8'h3D;

	// operator stack entry codes
	typedef enum logic [2:0] {
		CODE_LPAR = 3'd0,
		CODE_ADD  = 3'd1,
		CODE_SUB  = 3'd2,
		CODE_MUL  = 3'd3,
		CODE_DIV  = 3'd4
	} code_t;

	// character classes
	typedef enum logic [2:0] {
		CLS_OPERAND = 3'd0,
		CLS_LPAR    = 3'd1,
		CLS_RPAR    = 3'd2,
		CLS_OP      = 3'd3,
		CLS_EQ      = 3'd4,
		CLS_OTHER   = 3'd5
	} cls_t;

	// source of an emitted result
	typedef enum logic [1:0] {
		SEL_CHAR = 2'd0,
		SEL_TOP  = 2'd1,
		SEL_ERR  = 2'd2
	} sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_char;
		logic push;
		logic pop;
		logic emit;
		sel_t sel;
		logic last;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		cls_t cls;
		logic count_nz;
		logic full;
		logic top_pop;
		logic next_pop;
		logic out_free;
	} sts_t;

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
			(ch >= 8'h30 && ch <= 8'h39)) begin
			c = CLS_OPERAND;
		end else if (ch == CH_LPAR) begin
			c = CLS_LPAR;
		end else if (ch == CH_RPAR) begin
			c = CLS_RPAR;
		end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV) begin
			c = CLS_OP;
		end else if (ch == CH_EQ) begin
			c = CLS_EQ;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

	function automatic code_t char_to_code(input logic [7:0] ch);
		code_t c;
		if (ch == CH_ADD) begin
			c = CODE_ADD;
		end else if (ch == CH_SUB) begin
			c = CODE_SUB;
		end else if (ch == CH_MUL) begin
			c = CODE_MUL;
		end else if (ch == CH_DIV) begin
			c = CODE_DIV;
		end else begin
			c = CODE_LPAR;
		end
		return c;
	endfunction

	function automatic logic [7:0] code_to_char(input code_t code);
		logic [7:0] ch;
		case (code)
			CODE_LPAR: ch = CH_LPAR;
			CODE_ADD:  ch = CH_ADD;
			CODE_SUB:  ch = CH_SUB;
			CODE_MUL:  ch = CH_MUL;
			CODE_DIV:  ch = CH_DIV;
			default:   ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[rtl/core/ipc_dp.sv]
// datapath: character register, operator stack with cached top, result register
`timescale 1ns / 1ps

module ipc_dp #(
	parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_char,
	input  logic          out_ready,
	input  ipc_pkg::cmd_t cmd,
	output ipc_pkg::sts_t sts,
	output logic          out_valid,
	output logic [7:0]    out_char,
	output logic          out_last,
	output logic          out_err
);
	import ipc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0]    ch_q;
	code_t         top_q;
	code_t         rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] wr_idx;
	logic [CW-1:0] rd_idx;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic          we;
	logic          rd_en;
	logic          hi_prec;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;
	logic          out_err_q;

	// entries below the top; the top lives in top_q
	code_t stack_q [STACK_DEPTH];

	// pop decision for the item class against one stack entry
	function automatic logic pop_ok(input code_t t, input cls_t c, input logic hi);
		logic ok;
		case (c)
			CLS_EQ:   ok = 1'b1;
			CLS_RPAR: ok = (t != CODE_LPAR);
			CLS_OP:   ok = (t != CODE_LPAR) && !((t == CODE_ADD || t == CODE_SUB) && hi);
			default:  ok = 1'b0;
		endcase
		return ok;
	endfunction

	// next stack count and memory addresses
	always_comb begin
		cnt_d = count_q;
		if (cmd.push) begin
			cnt_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_d = count_q - CW'(1);
		end
		wr_idx = count_q - CW'(1);
		rd_idx = cnt_d - CW'(2);
		wa     = wr_idx[AW-1:0];
		ra     = rd_idx[AW-1:0];
		we     = cmd.push && (count_q != '0);
		rd_en  = (cnt_d >= CW'(2));
	end

	// status toward the controller
	always_comb begin
		hi_prec      = (char_to_code(ch_q) == CODE_MUL) || (char_to_code(ch_q) == CODE_DIV);
		sts.cls      = classify(ch_q);
		sts.count_nz = (count_q != '0);
		sts.full     = (count_q >= CW'(STACK_DEPTH));
		sts.top_pop  = sts.count_nz && pop_ok(top_q, sts.cls, hi_prec);
		sts.next_pop = (count_q >= CW'(2)) && pop_ok(rd_q, sts.cls, hi_prec);
		sts.out_free = !out_valid_q || out_ready;
	end

	// stack memory: old top spills on push, entry below the next top is read ahead
	always_ff @(posedge clk) begin
		if (we) begin
			stack_q[wa] <= top_q;
		end
		if (rd_en) begin
			if (we && (wa == ra)) begin
				rd_q <= top_q;
			end else begin
				rd_q <= stack_q[ra];
			end
		end
	end

	// stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= cnt_d;
		end
	end

	// character and cached top
	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			ch_q <= in_char;
		end
		if (cmd.push) begin
			top_q <= char_to_code(ch_q);
		end else if (cmd.pop) begin
			top_q <= rd_q;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q <= cmd.last;
			case (cmd.sel)
				SEL_CHAR: begin
					out_char_q <= ch_q;
					out_err_q  <= 1'b0;
				end
				SEL_TOP: begin
					out_char_q <= code_to_char(top_q);
					out_err_q  <= 1'b0;
				end
				default: begin
					out_char_q <= 8'h00;
					out_err_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

endmodule

[rtl/core/ipc_ctrl.sv]
// controller state machine: takes a request and steps the stack operations it calls for
`timescale 1ns / 1ps

module ipc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ipc_pkg::sts_t sts,
	output ipc_pkg::cmd_t cmd
);
	import ipc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done;

	// command decode per state and character class
	always_comb begin
		cmd       = '0;
		cmd.sel   = SEL_CHAR;
		done      = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_char = in_valid;
			end
			S_EXEC: begin
				case (sts.cls)
					CLS_OPERAND: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.sel  = SEL_CHAR;
							cmd.last = 1'b1;
							done     = 1'b1;
						end
					end
					CLS_LPAR: begin
						if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.sel  = SEL_ERR;
								cmd.last = 1'b1;
								done     = 1'b1;
							end
						end else begin
							cmd.push = 1'b1;
							done     = 1'b1;
						end
					end
					CLS_RPAR: begin
						if (sts.top_pop) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.pop  = 1'b1;
								cmd.sel  = SEL_TOP;
								cmd.last = !sts.next_pop;
							end
						end else begin
							// drop the matching open parenthesis if there is one
							cmd.pop = sts.count_nz;
							done    = 1'b1;
						end
					end
					CLS_OP: begin
						if (sts.top_pop) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.pop  = 1'b1;
								cmd.sel  = SEL_TOP;
								cmd.last = !sts.next_pop;
							end
						end else if (sts.full) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.sel  = SEL_ERR;
								cmd.last = 1'b1;
								done     = 1'b1;
							end
						end else begin
							cmd.push = 1'b1;
							done     = 1'b1;
						end
					end
					CLS_EQ: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							if (sts.count_nz) begin
								cmd.pop = 1'b1;
								cmd.sel = SEL_TOP;
							end else begin
								cmd.sel  = SEL_CHAR;
								cmd.last = 1'b1;
								done     = 1'b1;
							end
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (done) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/infix_to_postfix_converter_unit.sv]
// top level of the streaming infix to postfix converter
//
//   channel | dir | tdata           | tlast | tuser
//   s_axis  | in  | in_char [7:0]   | -     | -
//   m_axis  | out | out_char [7:0]  | last  | overflow_error
//
// a request is taken in the idle state, then the exec state emits its results one by one
// and returns to idle on its last result, or on a closing push, a dropped '(' or nothing at all
// pops run at one a cycle while the result register is free, fed by the stack read ahead of the top
// reset clears the stack count, the state machine and the result valid
// a stalled result holds in the output register and the state machine waits to emit its next one
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,
	output logic       m_tuser    // [0] overflow_error
);
	import ipc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	ipc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ipc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (s_tdata),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_char  (m_tdata),
		.out_last  (m_tlast),
		.out_err   (m_tuser)
	);

endmodule

[rtl/core/ipc_checker.sv]
// port level checks of the converter and their binding to the top level
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_unit_assert.svh"

module ipc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);
	import ipc_pkg::*;

	// result character is a stack symbol
	wire op_char = (m_tdata == CH_LPAR) || (m_tdata == CH_ADD) || (m_tdata == CH_SUB) ||
		(m_tdata == CH_MUL) || (m_tdata == CH_DIV);

	// a stalled result holds
	`IPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

	// one request at a time
	`IPC_ASSERT_NEXT(a_one_req, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// error result is zero and final
	`IPC_ASSERT_ALWAYS(a_err_form, clk, arst_n, !(m_tvalid && m_tuser) || (m_tdata == 8'h00 && m_tlast), "bad overflow result")

	// only stack pops come before the final result
	`IPC_ASSERT_ALWAYS(a_mid_pop, clk, arst_n, !(m_tvalid && !m_tlast) || op_char, "non-final result is not an operator")

endmodule

bind infix_to_postfix_converter_unit ipc_checker u_ipc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

[verif/tb.sv]
// self-checking testbench for the streaming infix to postfix converter
`timescale 1ns / 1ps

module tb;
	import ipc_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 87;

	// expected postfix stream, built from a private copy of the operator stack
	class postfix_scoreboard;
		code_t      op_stack[STACK_DEPTH];
		int         depth;
		logic [7:0] op_symbol[5];
		logic [7:0] exp_char[$];
		logic       exp_last[$];
		logic       exp_ovf[$];
		int         errors;
		int         results;
		int         overflows;

		function new();
			depth = 0;
			errors = 0;
			results = 0;
			overflows = 0;
			op_symbol[CODE_LPAR] = CH_LPAR;
			op_symbol[CODE_ADD] = CH_ADD;
			op_symbol[CODE_SUB] = CH_SUB;
			op_symbol[CODE_MUL] = CH_MUL;
			op_symbol[CODE_DIV] = CH_DIV;
		endfunction

		function void add_out(logic [7:0] ch, logic ovf);
			exp_char.push_back(ch);
			exp_last.push_back(1'b0);
			exp_ovf.push_back(ovf);
			if (ovf) begin
				overflows++;
			end
		endfunction

		function void pop_out();
			add_out(op_symbol[op_stack[depth - 1]], 1'b0);
			depth--;
		endfunction

		// a push onto a full stack is dropped and flagged
		function void push_code(code_t c);
			if (depth >= STACK_DEPTH) begin
				add_out(8'h00, 1'b1);
			end else begin
				op_stack[depth] = c;
				depth++;
			end
		endfunction

		function bit top_yields(bit high);
			code_t t;
			t = op_stack[depth - 1];
			if (t == CODE_LPAR) begin
				return 1'b1;
			end
			return high && (t == CODE_ADD || t == CODE_SUB);
		endfunction

		// note an accepted request; returns 0 when the block ignores the character
		function bit note_request(logic [7:0] ch);
			int    n_prev;
			bit    handled;
			bit    high;
			code_t c;
			n_prev = exp_char.size();
			handled = 1'b1;
			if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
				(ch >= "0" && ch <= "9")) begin
				add_out(ch, 1'b0);
			end else if (ch == CH_LPAR) begin
				push_code(CODE_LPAR);
			end else if (ch == CH_RPAR) begin
				// unwind to the matching paren, or to empty when none is open
				while (depth > 0 && op_stack[depth - 1] != CODE_LPAR) begin
					pop_out();
				end
				if (depth > 0) begin
					depth--;
				end
			end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV) begin
				c = (ch == CH_ADD) ? CODE_ADD : (ch == CH_SUB) ? CODE_SUB :
					(ch == CH_MUL) ? CODE_MUL : CODE_DIV;
				high = (c == CODE_MUL || c == CODE_DIV);
				while (depth > 0 && !top_yields(high)) begin
					pop_out();
				end
				push_code(c);
			end else if (ch == CH_EQ) begin
				while (depth > 0) begin
					pop_out();
				end
				add_out(CH_EQ, 1'b0);
			end else begin
				handled = 1'b0;
			end
			if (exp_char.size() > n_prev) begin
				exp_last[exp_last.size() - 1] = 1'b1;
			end
			return handled;
		endfunction

		function void check_result(logic [7:0] ch, logic lst, logic ovf);
			logic [7:0] e_ch;
			logic       e_last;
			logic       e_ovf;
			results++;
			if (exp_char.size() == 0) begin
				$error("unexpected result: out_char %h last %b overflow_error %b", ch, lst, ovf);
				errors++;
				return;
			end
			e_ch = exp_char.pop_front();
			e_last = exp_last.pop_front();
			e_ovf = exp_ovf.pop_front();
			if (ch !== e_ch) begin
				$error("out_char: expected %h, got %h", e_ch, ch);
				errors++;
			end
			if (lst !== e_last) begin
				$error("last: expected %b, got %b", e_last, lst);
				errors++;
			end
			if (ovf !== e_ovf) begin
				$error("overflow_error: expected %b, got %b", e_ovf, ovf);
				errors++;
			end
		endfunction

		function int pending();
			return exp_char.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	postfix_scoreboard sb;
	int tx_idle_pct = 35;
	int rx_idle_pct = 78;
	int sent_cnt = 0;
	int handled_cnt = 0;
	int quiet_cycles = 0;

	infix_to_postfix_converter_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tlast, m_tuser);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one request, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] ch);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sent_cnt++;
		if (sb.note_request(ch)) begin
			handled_cnt++;
		end
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	function automatic logic [7:0] rand_operand();
		logic [7:0] ch;
		case ($urandom_range(2))
			0: ch = 8'h61 + 8'($urandom_range(25));
			1: ch = 8'h41 + 8'($urandom_range(25));
			default: ch = 8'h30 + 8'($urandom_range(9));
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] rand_operator();
		logic [7:0] ch;
		case ($urandom_range(3))
			0: ch = CH_ADD;
			1: ch = CH_SUB;
			2: ch = CH_MUL;
			default: ch = CH_DIV;
		endcase
		return ch;
	endfunction

	// well-formed expression with random nesting, closed by '='
	task automatic send_expr();
		int terms;
		int open;
		terms = $urandom_range(1, 7);
		open = 0;
		for (int i = 0; i < terms; i++) begin
			while (open < 5 && $urandom_range(3) == 0) begin
				send_char(CH_LPAR);
				open++;
			end
			send_char(rand_operand());
			while (open > 0 && $urandom_range(2) == 0) begin
				send_char(CH_RPAR);
				open--;
			end
			if (i < terms - 1) begin
				send_char(rand_operator());
			end
		end
		while (open > 0) begin
			send_char(CH_RPAR);
			open--;
		end
		send_char(CH_EQ);
	endtask

	// nest close to or past the stack depth so pushes hit a full stack
	task automatic send_deep();
		int fill;
		fill = $urandom_range(28, 36);
		for (int i = 0; i < fill; i++) begin
			if ($urandom_range(3) == 0) begin
				send_char(rand_operand());
				send_char(rand_operator());
			end else begin
				send_char(CH_LPAR);
			end
		end
		case ($urandom_range(2))
			0: send_char(CH_LPAR);
			1: send_char(rand_operator());
			default: send_char(CH_RPAR);
		endcase
		if ($urandom_range(1) == 1) begin
			repeat ($urandom_range(1, 40)) send_char(CH_RPAR);
		end
		send_char(CH_EQ);
	endtask

	// broken sequences: symbols in any order, stray parens
	task automatic send_broken();
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(4))
				0: send_char(CH_LPAR);
				1: send_char(CH_RPAR);
				2: send_char(CH_EQ);
				3: send_char(rand_operator());
				default: send_char(rand_operand());
			endcase
		end
	endtask

	task automatic send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_expr();
		end else if (pick < 78) begin
			send_deep();
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
		end else begin
			send_broken();
		end
	endtask

	// sender holds off until every expected result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operand extremes, ignored bytes, unmatched ')', precedence, flush
		send_string("Az09");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h20);
		send_string(")(a+b*c-d/e))x*y+z==");

		// random phases with different idle patterns
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			case (ph)
				0: begin
					tx_idle_pct = 35;
					rx_idle_pct = 78;
				end
				1: begin
					tx_idle_pct = 78;
					rx_idle_pct = 35;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			while (sent_cnt < (ph + 1) * ITEMS_PER_PHASE) begin
				send_random();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("sent %0d characters, %0d of them acted on", sent_cnt, handled_cnt);
		$display("checked %0d postfix results, %0d of them stack overflows",
			sb.results, sb.overflows);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
